>>> hw/rtl/mip_pkg.sv
`default_nettype none

package mip_pkg;

  localparam int unsigned MOD_BITS = 31;
  localparam int unsigned VAL_BITS = 64;
  localparam int unsigned CNT_BITS = 6;
  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1000000007);
  localparam logic [MOD_BITS-1:0] EXP_OFFSET = MOD_BITS'(2);
  localparam logic [CNT_BITS-1:0] REDUCE_LAST = CNT_BITS'(VAL_BITS - 1);
  localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MOD_BITS - 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_REDUCE  = 6'b000010,
    ST_FIXNEG  = 6'b000100,
    ST_NEXTBIT = 6'b001000,
    ST_MUL_ACC = 6'b010000,
    ST_MUL_SQR = 6'b100000
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/modular_inverse_by_power_top.sv
`default_nettype none

// Computes (value mod m)^(m-2) mod m, the inverse of value for a prime modulus m. An item is
// taken when start_i is high and busy_o is low; busy_o then stays high until the result has been
// shown. The result appears on inverse_o for exactly one cycle with done_o high and cannot be
// stalled, so the receiver must take it in that cycle. One bit-serial modular multiply-add unit
// does all the work: the 64-bit operand is reduced one bit at a time, then each exponent bit up
// to the highest set bit of m-2 costs one squaring plus, for a set bit, one multiply, each done
// bit-serially, with one sequencing state per bit. A modulus below two gives a result of zero
// in the cycle after the item is taken. The modulus may only be written while idle.
module modular_inverse_by_power_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [mip_pkg::VAL_BITS-1:0] value_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [mip_pkg::MOD_BITS-1:0] cfg_wdata_i,
  output logic                              done_o,
  output logic [mip_pkg::MOD_BITS-1:0]      inverse_o
);

  localparam int unsigned MW = mip_pkg::MOD_BITS;
  localparam int unsigned VW = mip_pkg::VAL_BITS;
  localparam int unsigned CW = mip_pkg::CNT_BITS;

  mip_pkg::state_e state_q, state_d;
  logic [MW-1:0]   modulus_q;
  logic [VW-1:0]   mag_q, mag_d;
  logic            neg_q, neg_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [MW-1:0]   p_q, p_d;
  logic [MW-1:0]   base_q, base_d;
  logic [MW-1:0]   acc_q, acc_d;
  logic [MW-1:0]   exp_q, exp_d;
  logic [MW-1:0]   mb_q, mb_d;
  logic            done_q, done_d;

  logic [MW-1:0]   addend;
  logic [MW+1:0]   sum;
  logic [MW+1:0]   sum_m1;
  logic [MW+1:0]   sum_m2;
  logic [MW+1:0]   mod_x1;
  logic [MW+1:0]   mod_x2;
  logic [MW-1:0]   step_res;

  // Shared step: p <- (2p + addend) mod m, with 2p + addend below 3m.
  always_comb begin
    if (state_q == mip_pkg::ST_REDUCE) begin
      addend = {{(MW-1){1'b0}}, mag_q[VW-1]};
    end else begin
      addend = mb_q[MW-1] ? base_q : '0;
    end
    mod_x1   = {2'b00, modulus_q};
    mod_x2   = {1'b0, modulus_q, 1'b0};
    sum      = {1'b0, p_q, 1'b0} + {2'b00, addend};
    sum_m1   = sum - mod_x1;
    sum_m2   = sum - mod_x2;
    if (sum >= mod_x2) begin
      step_res = sum_m2[MW-1:0];
    end else if (sum >= mod_x1) begin
      step_res = sum_m1[MW-1:0];
    end else begin
      step_res = sum[MW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    base_d  = base_q;
    acc_d   = acc_q;
    exp_d   = exp_q;
    mb_d    = mb_q;
    done_d  = 1'b0;
    case (state_q)
      mip_pkg::ST_IDLE: begin
        if (start_i && !done_q) begin
          if (modulus_q < mip_pkg::EXP_OFFSET) begin
            acc_d  = '0;
            done_d = 1'b1;
          end else begin
            neg_d   = value_i[VW-1];
            mag_d   = value_i[VW-1] ? (~value_i + VW'(1)) : value_i;
            p_d     = '0;
            cnt_d   = '0;
            state_d = mip_pkg::ST_REDUCE;
          end
        end
      end
      mip_pkg::ST_REDUCE: begin
        p_d   = step_res;
        mag_d = {mag_q[VW-2:0], 1'b0};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == mip_pkg::REDUCE_LAST) begin
          state_d = mip_pkg::ST_FIXNEG;
        end
      end
      mip_pkg::ST_FIXNEG: begin
        base_d  = (neg_q && (p_q != '0)) ? (modulus_q - p_q) : p_q;
        acc_d   = MW'(1);
        exp_d   = modulus_q - mip_pkg::EXP_OFFSET;
        state_d = mip_pkg::ST_NEXTBIT;
      end
      mip_pkg::ST_NEXTBIT: begin
        p_d   = '0;
        cnt_d = '0;
        if (exp_q == '0) begin
          done_d  = 1'b1;
          state_d = mip_pkg::ST_IDLE;
        end else if (exp_q[0]) begin
          mb_d    = acc_q;
          state_d = mip_pkg::ST_MUL_ACC;
        end else begin
          mb_d    = base_q;
          state_d = mip_pkg::ST_MUL_SQR;
        end
      end
      mip_pkg::ST_MUL_ACC: begin
        p_d   = step_res;
        mb_d  = {mb_q[MW-2:0], 1'b0};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == mip_pkg::MUL_LAST) begin
          acc_d   = step_res;
          p_d     = '0;
          cnt_d   = '0;
          mb_d    = base_q;
          state_d = mip_pkg::ST_MUL_SQR;
        end
      end
      mip_pkg::ST_MUL_SQR: begin
        p_d   = step_res;
        mb_d  = {mb_q[MW-2:0], 1'b0};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == mip_pkg::MUL_LAST) begin
          base_d  = step_res;
          exp_d   = {1'b0, exp_q[MW-1:1]};
          state_d = mip_pkg::ST_NEXTBIT;
        end
      end
      default: begin
        state_d = mip_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mip_pkg::ST_IDLE;
      modulus_q <= mip_pkg::MOD_RESET;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    p_q    <= p_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    exp_q  <= exp_d;
    mb_q   <= mb_d;
  end

  assign busy_o    = (state_q != mip_pkg::ST_IDLE) || done_q;
  assign done_o    = done_q;
  assign inverse_o = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/mip_checker.sv
`default_nettype none

module mip_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic [mip_pkg::VAL_BITS-1:0] value_i,
  input wire logic                         cfg_we_i,
  input wire logic [mip_pkg::MOD_BITS-1:0] cfg_wdata_i,
  input wire logic                         done_o,
  input wire logic [mip_pkg::MOD_BITS-1:0] inverse_o
);

  logic [mip_pkg::MOD_BITS-1:0] mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mip_pkg::MOD_RESET;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result shown while not busy");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised after an item");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_busy_ends_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(done_o)) else $error("busy dropped without a result");

  a_result_below_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (mod_q > mip_pkg::MOD_BITS'(1)) && !$past(cfg_we_i) |-> inverse_o < mod_q)
    else $error("result not reduced below the modulus");

  logic unused_value;
  assign unused_value = ^value_i;

endmodule

bind modular_inverse_by_power_top mip_checker u_mip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .value_i     (value_i),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .done_o      (done_o),
  .inverse_o   (inverse_o)
);

`default_nettype wire
